// ===== hw/rtl/bb_pkg.sv =====
// Shared constants and control types for the 9x9 RGBA box blur.
`timescale 1ns / 1ps
`default_nettype none
package bb_pkg;
  localparam int MAX_WIDTH_DEF   = 1024;
  localparam int RADIUS_DEF      = 4;
  localparam int MAX_HEIGHT      = 4096;
  localparam int CFG_WIDTH_BITS  = 11;
  localparam int CFG_HEIGHT_BITS = 13;
  localparam int CFG_DATA_BITS   = 13;
  localparam int ROW_W           = 13;
  localparam int WIDTH_RESET     = 1024;
  localparam int HEIGHT_RESET    = 768;
  localparam int PIX_BITS        = 32;
  localparam int CHANS           = 3;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef struct packed {
    logic take;
    logic scan_init;
    logic scan_step;
    logic div_init;
    logic div_step;
    logic out_load;
  } ctrl_t;

  typedef struct packed {
    logic due;
    logic scan_end;
    logic div_done;
    logic out_full;
  } status_t;
endpackage
`default_nettype wire

// ===== hw/rtl/bb_div.sv =====
// Three-lane restoring divider that shares one divisor and one step counter.
`timescale 1ns / 1ps
`default_nettype none
module bb_div
  import bb_pkg::*;
#(
  parameter int SUM_W = 15,
  parameter int CNT_W = 7
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic                         step,
  input  logic [CHANS-1:0][SUM_W-1:0]  num,
  input  logic [CNT_W-1:0]             divisor,
  output logic [CHANS-1:0][SUM_W-1:0]  quo,
  output logic                         done
);
  localparam int STEP_W = $clog2(SUM_W + 1);

  logic [CHANS-1:0][CNT_W-1:0] rem;
  logic [CHANS-1:0][CNT_W-1:0] rem_next;
  logic [CHANS-1:0][SUM_W-1:0] quo_next;
  logic [CNT_W-1:0]            dvs;
  logic [STEP_W-1:0]           steps;
  logic                        busy;

  assign done = (steps == STEP_W'(SUM_W));

  always_comb begin
    logic [CNT_W:0] trial;
    trial = '0;
    for (int i = 0; i < CHANS; i++) begin
      trial = {rem[i], quo[i][SUM_W-1]};
      if (trial >= {1'b0, dvs}) begin
        rem_next[i] = CNT_W'(trial - {1'b0, dvs});
        quo_next[i] = {quo[i][SUM_W-2:0], 1'b1};
      end else begin
        rem_next[i] = trial[CNT_W-1:0];
        quo_next[i] = {quo[i][SUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      busy  <= 1'b0;
    end else if (start) begin
      steps <= '0;
      busy  <= 1'b1;
    end else if (step && busy && !done) begin
      steps <= steps + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= num;
      rem <= '0;
      dvs <= divisor;
    end else if (step && busy && !done) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/bb_dp.sv =====
// Datapath: frame counters, row store, window scan, sums, divider and output register.
`timescale 1ns / 1ps
`default_nettype none
module bb_dp
  import bb_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int RADIUS    = RADIUS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic [PIX_BITS-1:0]      s_tdata,
  input  logic                     s_tuser,
  input  ctrl_t                    ctrl,
  output status_t                  status,
  input  logic                     m_tready,
  output logic                     m_tvalid,
  output logic [PIX_BITS-1:0]      m_tdata,
  output logic                     m_tlast
);
  localparam int STORE_ROWS = 3 * RADIUS + 1;
  localparam int DEPTH      = STORE_ROWS * MAX_WIDTH;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = $clog2(MAX_WIDTH + 1);
  localparam int SLOT_W     = $clog2(STORE_ROWS);
  localparam int WIN        = (2 * RADIUS + 1) * (2 * RADIUS + 1);
  localparam int CNT_W      = $clog2(WIN + 1);
  localparam int SUM_W      = $clog2(WIN * 255 + 1);
  localparam int LAG_W      = $clog2(RADIUS * MAX_WIDTH + RADIUS + 2);

  logic [PIX_BITS-1:0] mem [DEPTH];

  logic [CFG_WIDTH_BITS-1:0]  width_reg;
  logic [CFG_HEIGHT_BITS-1:0] height_reg;
  logic [WID_W-1:0]           eff_w;
  logic [ROW_W-1:0]           eff_h;
  logic [LAG_W-1:0]           lag;

  logic [COL_W-1:0]  in_col, out_col;
  logic [ROW_W-1:0]  in_row, out_row;
  logic [SLOT_W-1:0] in_slot, out_slot;
  logic [LAG_W-1:0]  items;

  logic [ROW_W-1:0]  sc_row, sc_r1;
  logic [COL_W-1:0]  sc_col, sc_c0, sc_c1;
  logic [SLOT_W-1:0] sc_slot;

  logic [ROW_W-1:0]  win_r0, win_r1;
  logic [COL_W-1:0]  win_c0, win_c1;
  logic [SLOT_W-1:0] win_slot, win_dist;
  logic [WID_W:0]    col_hi;

  logic                       in_active, counts, pixel_wr;
  logic                       in_col_wrap, out_col_wrap, frame_end;
  logic [ADDR_W-1:0]          wr_addr, rd_addr;
  logic [PIX_BITS-1:0]        rd_data;
  logic                       rd_valid, rd_centre;
  logic [CHANS-1:0][SUM_W-1:0] acc;
  logic [CHANS-1:0][SUM_W-1:0] quo;
  logic [CNT_W-1:0]           npix;
  logic [7:0]                 alpha_c;
  logic                       div_done;

  always_comb begin
    if (width_reg == '0) begin
      eff_w = WID_W'(1);
    end else if (32'(width_reg) > MAX_WIDTH) begin
      eff_w = WID_W'(MAX_WIDTH);
    end else begin
      eff_w = WID_W'(width_reg);
    end
    if (height_reg == '0) begin
      eff_h = ROW_W'(1);
    end else if (32'(height_reg) > MAX_HEIGHT) begin
      eff_h = ROW_W'(MAX_HEIGHT);
    end else begin
      eff_h = ROW_W'(height_reg);
    end
  end

  assign lag = LAG_W'(RADIUS * 32'(eff_w) + RADIUS);

  assign in_active    = in_row < eff_h;
  assign counts       = !in_active || !s_tuser;
  assign pixel_wr     = ctrl.take && in_active && !s_tuser;
  assign in_col_wrap  = (WID_W'(in_col) + WID_W'(1)) >= eff_w;
  assign out_col_wrap = (WID_W'(out_col) + WID_W'(1)) >= eff_w;
  assign frame_end    = out_col_wrap && ((out_row + ROW_W'(1)) >= eff_h);

  assign status.due      = counts && (items >= lag);
  assign status.scan_end = (sc_row == sc_r1) && (sc_col == sc_c1);
  assign status.div_done = div_done;
  assign status.out_full = m_tvalid;

  always_comb begin
    win_r0   = (out_row >= ROW_W'(RADIUS)) ? out_row - ROW_W'(RADIUS) : '0;
    win_r1   = (out_row + ROW_W'(RADIUS) > eff_h - ROW_W'(1)) ?
               eff_h - ROW_W'(1) : out_row + ROW_W'(RADIUS);
    win_dist = SLOT_W'(out_row - win_r0);
    win_slot = (out_slot >= win_dist) ? out_slot - win_dist :
               SLOT_W'(out_slot + SLOT_W'(STORE_ROWS) - win_dist);
    win_c0   = (out_col >= COL_W'(RADIUS)) ? out_col - COL_W'(RADIUS) : '0;
    col_hi   = (WID_W + 1)'(out_col) + (WID_W + 1)'(RADIUS);
    win_c1   = (col_hi > (WID_W + 1)'(eff_w) - (WID_W + 1)'(1)) ?
               COL_W'(eff_w - WID_W'(1)) : COL_W'(col_hi);
  end

  assign wr_addr = ADDR_W'(32'(in_slot) * MAX_WIDTH) + ADDR_W'(in_col);
  assign rd_addr = ADDR_W'(32'(sc_slot) * MAX_WIDTH) + ADDR_W'(sc_col);

  always_ff @(posedge clk) begin
    if (pixel_wr) begin
      mem[wr_addr] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.scan_step) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width_reg  <= CFG_WIDTH_BITS'(WIDTH_RESET);
      height_reg <= CFG_HEIGHT_BITS'(HEIGHT_RESET);
    end else if (cfg_valid) begin
      if (cfg_index == REG_WIDTH) begin
        width_reg <= cfg_data[CFG_WIDTH_BITS-1:0];
      end else begin
        height_reg <= cfg_data[CFG_HEIGHT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_valid || (ctrl.out_load && frame_end)) begin
      in_col   <= '0;
      in_row   <= '0;
      in_slot  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_slot <= '0;
      items    <= '0;
    end else begin
      if (ctrl.take && counts && (items <= lag)) begin
        items <= items + LAG_W'(1);
      end
      if (pixel_wr) begin
        if (in_col_wrap) begin
          in_col  <= '0;
          in_row  <= in_row + ROW_W'(1);
          in_slot <= (in_slot == SLOT_W'(STORE_ROWS - 1)) ? '0 : in_slot + SLOT_W'(1);
        end else begin
          in_col <= in_col + COL_W'(1);
        end
      end
      if (ctrl.out_load) begin
        if (out_col_wrap) begin
          out_col  <= '0;
          out_row  <= out_row + ROW_W'(1);
          out_slot <= (out_slot == SLOT_W'(STORE_ROWS - 1)) ? '0 : out_slot + SLOT_W'(1);
        end else begin
          out_col <= out_col + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.scan_init) begin
      sc_row  <= win_r0;
      sc_r1   <= win_r1;
      sc_col  <= win_c0;
      sc_c0   <= win_c0;
      sc_c1   <= win_c1;
      sc_slot <= win_slot;
    end else if (ctrl.scan_step) begin
      if (sc_col == sc_c1) begin
        sc_col  <= sc_c0;
        sc_row  <= sc_row + ROW_W'(1);
        sc_slot <= (sc_slot == SLOT_W'(STORE_ROWS - 1)) ? '0 : sc_slot + SLOT_W'(1);
      end else begin
        sc_col <= sc_col + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid  <= 1'b0;
      rd_centre <= 1'b0;
    end else begin
      rd_valid  <= ctrl.scan_step;
      rd_centre <= ctrl.scan_step && (sc_row == out_row) && (sc_col == out_col);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.scan_init) begin
      acc  <= '0;
      npix <= '0;
    end else if (rd_valid) begin
      for (int i = 0; i < CHANS; i++) begin
        acc[i] <= acc[i] + SUM_W'(rd_data[8*i +: 8]);
      end
      npix <= npix + CNT_W'(1);
    end
    if (rd_centre) begin
      alpha_c <= rd_data[31:24];
    end
  end

  bb_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (ctrl.div_init),
    .step    (ctrl.div_step),
    .num     (acc),
    .divisor (npix),
    .quo     (quo),
    .done    (div_done)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      m_tdata <= {alpha_c, quo[2][7:0], quo[1][7:0], quo[0][7:0]};
      m_tlast <= frame_end;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/bb_ctrl.sv =====
// Controller state machine that sequences accept, window scan, divide and output.
`timescale 1ns / 1ps
`default_nettype none
module bb_ctrl
  import bb_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  input  status_t status,
  output ctrl_t   ctrl
);
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SCAN   = 3'd1;
  localparam logic [2:0] S_WAIT   = 3'd2;
  localparam logic [2:0] S_DSTART = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_OUT    = 3'd5;

  logic [2:0] state, state_next;

  assign s_tready = (state == S_IDLE);

  always_comb begin
    ctrl       = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          ctrl.take = 1'b1;
          if (status.due) begin
            ctrl.scan_init = 1'b1;
            state_next     = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ctrl.scan_step = 1'b1;
        if (status.scan_end) begin
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        state_next = S_DSTART;
      end
      S_DSTART: begin
        ctrl.div_init = 1'b1;
        state_next    = S_DIV;
      end
      S_DIV: begin
        ctrl.div_step = 1'b1;
        if (status.div_done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!status.out_full) begin
          ctrl.out_load = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end
endmodule
`default_nettype wire

// ===== hw/rtl/box_blur_9x9_rgba_top.sv =====
// Top level of the edge-clipped RGBA box blur.
//
// Channel   Direction  Signals                        Content
// config    in         cfg_valid/cfg_ready            cfg_index, cfg_data
// pixel in  in         s_tvalid/s_tready              s_tdata, s_tuser
// pixel out out        m_tvalid/m_tready              m_tdata, m_tlast
//
// An item that yields no result is taken while the controller stays idle. An item
// that yields a result starts a window scan, a divide and an output load, whose
// duration is set by the single read port of the row store, which reads one window
// pixel a cycle, and by the bit-serial divider. The output register lets the next
// transfer in while a result waits. Reset is synchronous and needs no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module box_blur_9x9_rgba_top
  import bb_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int RADIUS    = RADIUS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic                     cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [PIX_BITS-1:0]      s_tdata,  // red_in, green_in, blue_in, alpha_in
  input  logic                     s_tuser,  // operation
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [PIX_BITS-1:0]      m_tdata,  // red_out, green_out, blue_out, alpha_out
  output logic                     m_tlast
);
  ctrl_t   ctrl;
  status_t status;

  assign cfg_ready = 1'b1;

  bb_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .ctrl     (ctrl)
  );

  bb_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .RADIUS    (RADIUS)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .ctrl      (ctrl),
    .status    (status),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );
endmodule
`default_nettype wire

// ===== hw/rtl/bb_check.sv =====
// Port-level checker for the box blur top level and its bind statement.
`timescale 1ns / 1ps
`default_nettype none
module bb_check
  import bb_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [PIX_BITS-1:0]      m_tdata,
  input logic                     m_tlast
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
    else $error("result appeared one cycle after a transfer");
endmodule

bind box_blur_9x9_rgba_top bb_check u_check (.*);
`default_nettype wire

// ===== verif/box_blur_9x9_rgba_top_tb.sv =====
// Self-checking testbench for the 9x9 RGBA box blur with its own window-mean predictor.
`timescale 1ns / 1ps
`default_nettype none
module box_blur_9x9_rgba_top_tb;
  import bb_pkg::*;

  localparam int STORE_ROWS = 3 * RADIUS_DEF + 1;
  localparam int SETTLE = 150;

  typedef struct packed {
    logic [31:0] pix;
    logic        last;
  } blur_res_t;

  typedef struct packed {
    logic        drain;
    logic [31:0] pix;
    logic        typed;
    logic [31:0] epix;
    logic        elast;
  } stim_row_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic                     cfg_index;
  logic [CFG_DATA_BITS-1:0] cfg_data;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [PIX_BITS-1:0]      s_tdata;
  logic                     s_tuser;
  logic                     m_tvalid;
  logic                     m_tready;
  logic [PIX_BITS-1:0]      m_tdata;
  logic                     m_tlast;

  box_blur_9x9_rgba_top i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  // Shadow of the block: row store, registers and raster counters.
  logic [31:0] px_store [STORE_ROWS][MAX_WIDTH_DEF];
  int unsigned width_reg, height_reg;
  int unsigned in_col, in_row, out_col, out_row, frame_items;

  blur_res_t pending_blur[$];
  int errors, items_sent, results_seen, frames_done;
  int tx_idle, rx_idle;
  logic hold_req, hold_seen;
  int hold_cnt;
  logic frame_closed;

  stim_row_t opening_rows[19] = '{
    '{1'b1, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b0, 32'h80FF00FF, 1'b0, 32'h0, 1'b0},
    '{1'b1, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b1, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b1, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b1, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b1, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b1, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b1, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b0, 32'h12345678, 1'b1, 32'h80FF00FF, 1'b1},
    '{1'b0, 32'h7F00FF00, 1'b0, 32'h0, 1'b0},
    '{1'b1, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b1, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b1, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b1, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b1, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b1, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b1, 32'h0, 1'b0, 32'h0, 1'b0},
    '{1'b1, 32'h0, 1'b1, 32'h7F00FF00, 1'b1}
  };

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  function automatic int unsigned eff_width();
    if (width_reg == 0) return 1;
    if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    if (height_reg == 0) return 1;
    if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
    return height_reg;
  endfunction

  function automatic void restart_raster();
    in_col = 0;
    in_row = 0;
    out_col = 0;
    out_row = 0;
    frame_items = 0;
  endfunction

  // Advances the shadow by one accepted item; returns 1 when a blurred pixel is due.
  function automatic bit blur_step(input logic drain, input logic [31:0] pix,
                                   output bit ignored, output blur_res_t res);
    int unsigned w, h, r0, r1, c0, c1, cnt;
    int unsigned sum_r, sum_g, sum_b;
    logic [31:0] p;
    w = eff_width();
    h = eff_height();
    ignored = 1'b0;
    res = '0;
    if (in_row < h) begin
      if (drain) begin
        ignored = 1'b1;
        return 1'b0;
      end
      px_store[in_row % STORE_ROWS][in_col] = pix;
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
      end
    end
    frame_items++;
    if (frame_items <= RADIUS_DEF * w + RADIUS_DEF) return 1'b0;
    r0 = out_row >= RADIUS_DEF ? out_row - RADIUS_DEF : 0;
    r1 = out_row + RADIUS_DEF > h - 1 ? h - 1 : out_row + RADIUS_DEF;
    c0 = out_col >= RADIUS_DEF ? out_col - RADIUS_DEF : 0;
    c1 = out_col + RADIUS_DEF > w - 1 ? w - 1 : out_col + RADIUS_DEF;
    sum_r = 0;
    sum_g = 0;
    sum_b = 0;
    for (int unsigned r = r0; r <= r1; r++) begin
      for (int unsigned c = c0; c <= c1; c++) begin
        p = px_store[r % STORE_ROWS][c];
        sum_r += p[7:0];
        sum_g += p[15:8];
        sum_b += p[23:16];
      end
    end
    cnt = (r1 - r0 + 1) * (c1 - c0 + 1);
    p = px_store[out_row % STORE_ROWS][out_col];
    res.pix = {p[31:24], 8'(sum_b / cnt), 8'(sum_g / cnt), 8'(sum_r / cnt)};
    out_col++;
    if (out_col >= w) begin
      out_col = 0;
      out_row++;
    end
    if (out_row >= h) begin
      res.last = 1'b1;
      restart_raster();
    end
    return 1'b1;
  endfunction

  task automatic send_item(input logic drain, input logic [31:0] pix,
                           input logic typed, input blur_res_t typed_res);
    bit due, ignored;
    blur_res_t res;
    while ($urandom_range(99) < tx_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= drain;
    s_tdata  <= pix;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    due = blur_step(drain, pix, ignored, res);
    if (!ignored) items_sent++;
    if (typed) pending_blur = {pending_blur, typed_res};
    else if (due) pending_blur = {pending_blur, res};
    frame_closed = due && res.last;
  endtask

  task automatic write_reg(input logic idx, input int unsigned value);
    s_tvalid <= 1'b0;
    while (pending_blur.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_BITS'(value);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_WIDTH) width_reg = value & 32'h7FF;
    else height_reg = value & 32'h1FFF;
    restart_raster();
  endtask

  // One frame: random pixels, then drains; noisy ones add strays of each and may stop early.
  task automatic run_frame(input int unsigned wv, input int unsigned hv,
                           input bit noisy);
    int unsigned npix;
    write_reg(REG_WIDTH, wv);
    write_reg(REG_HEIGHT, hv);
    npix = eff_width() * eff_height();
    frame_closed = 1'b0;
    for (int unsigned k = 0; k < npix; k++) begin
      if (noisy && $urandom_range(99) < 4) send_item(1'b1, $urandom, 1'b0, '0);
      if (noisy && $urandom_range(999) < 3) return;
      send_item(1'b0, $urandom, 1'b0, '0);
    end
    while (!frame_closed) begin
      if (noisy && $urandom_range(9) == 0) send_item(1'b0, $urandom, 1'b0, '0);
      else send_item(1'b1, $urandom, 1'b0, '0);
    end
    frames_done++;
  endtask

  always @(posedge clk) begin
    blur_res_t want;
    if (rst) begin
      m_tready  <= 1'b0;
      hold_cnt  <= 0;
      hold_seen <= 1'b0;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen <= hold_req;
        hold_cnt  <= 400;
        m_tready  <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= $urandom_range(99) >= rx_idle;
      end
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (pending_blur.size() == 0) begin
          $error("unexpected transfer: data %h last %b", m_tdata, m_tlast);
          errors++;
        end else begin
          want = pending_blur.pop_front();
          if (m_tdata[7:0] !== want.pix[7:0]) begin
            $error("red_out: expected %0d, got %0d", want.pix[7:0], m_tdata[7:0]);
            errors++;
          end
          if (m_tdata[15:8] !== want.pix[15:8]) begin
            $error("green_out: expected %0d, got %0d", want.pix[15:8], m_tdata[15:8]);
            errors++;
          end
          if (m_tdata[23:16] !== want.pix[23:16]) begin
            $error("blue_out: expected %0d, got %0d", want.pix[23:16], m_tdata[23:16]);
            errors++;
          end
          if (m_tdata[31:24] !== want.pix[31:24]) begin
            $error("alpha_out: expected %0d, got %0d", want.pix[31:24], m_tdata[31:24]);
            errors++;
          end
          if (m_tlast !== want.last) begin
            $error("frame_end: expected %b, got %b", want.last, m_tlast);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    blur_res_t typed_res;
    errors = 0;
    items_sent = 0;
    results_seen = 0;
    frames_done = 0;
    tx_idle = 29;
    rx_idle = 64;
    hold_req = 1'b0;
    frame_closed = 1'b0;
    width_reg = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    restart_raster();
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tuser = 1'b0;
    s_tdata = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A few pixels at the reset geometry, far short of the lag.
    for (int k = 0; k < 4; k++) send_item(1'b0, $urandom, 1'b0, '0);

    // Single-pixel frames with both registers written as zero.
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 0);
    for (int k = 0; k < 19; k++) begin
      typed_res.pix  = opening_rows[k].epix;
      typed_res.last = opening_rows[k].elast;
      send_item(opening_rows[k].drain, opening_rows[k].pix,
                opening_rows[k].typed, typed_res);
    end

    while (items_sent < 1700) begin
      if (items_sent >= 1200) begin
        tx_idle = 0;
        rx_idle = 0;
      end else if (items_sent >= 600) begin
        tx_idle = 64;
        rx_idle = 29;
      end
      if (frames_done == 3) hold_req <= ~hold_req;
      if ($urandom_range(9) == 0)
        run_frame($urandom_range(10, 20), $urandom_range(10, 20), 1'b1);
      else
        run_frame($urandom_range(0, 10), $urandom_range(0, 10), 1'b1);
    end

    // Register values beyond the field widths, which wrap to small sizes.
    tx_idle = 0;
    rx_idle = 0;
    run_frame(2049, 3, 1'b0);
    run_frame(3, 8193, 1'b0);

    s_tvalid <= 1'b0;
    while (pending_blur.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d accepted items, %0d blurred pixels, %0d complete frames.",
             items_sent, results_seen, frames_done);
    if (errors == 0 && pending_blur.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
